[rtl/sucs_pkg.sv]
// Shared types, constants and command/status groups of the unique common substring search.
`timescale 1ns / 1ps

package sucs_pkg;

    // Default string capacity in bytes
    localparam int MAX_LEN_DEF = 256;

    // Width of the reported length field
    localparam int LENGTH_W = 9;

    // Request modes
    localparam logic [1:0] MODE_LOAD_FIRST  = 2'd0;
    localparam logic [1:0] MODE_LOAD_SECOND = 2'd1;
    localparam logic [1:0] MODE_SEARCH      = 2'd2;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] symbol;
    } t_in_req;

    typedef struct packed {
        logic                found;
        logic [LENGTH_W-1:0] length;
        logic                overflow;
    } t_out_req;

    // Controller to datapath
    typedef struct packed {
        logic load_first;
        logic load_second;
        logic start;
        logic issue;
        logic eval;
        logic finish;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic empty;
        logic sweep_last;
        logic row_last;
    } t_status;

endpackage

[rtl/sucs_ctrl.sv]
// Sequencer of the unique common substring search: handshakes and row sweep control.
`timescale 1ns / 1ps

module sucs_ctrl
    import sucs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_mode,
    output logic       o_in_stall,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_cmd       o_cmd,
    input  t_status    i_status
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SWEEP = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_EVAL  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       accept;

    // A search waits for the previous result to leave; loads never wait on it
    assign o_in_stall = (r_state != S_IDLE) || ((i_mode == MODE_SEARCH) && r_out_valid);
    assign accept     = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_mode)
                        MODE_LOAD_FIRST:  o_cmd.load_first  = 1'b1;
                        MODE_LOAD_SECOND: o_cmd.load_second = 1'b1;
                        MODE_SEARCH: begin
                            o_cmd.start = 1'b1;
                            n_state = i_status.empty ? S_DONE : S_SWEEP;
                        end
                        default: ;
                    endcase
                end
            end
            S_SWEEP: begin
                o_cmd.issue = 1'b1;
                if (i_status.sweep_last) n_state = S_DRAIN;
            end
            S_DRAIN: n_state = S_EVAL;
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state = i_status.row_last ? S_DONE : S_SWEEP;
            end
            S_DONE: begin
                o_cmd.finish = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign n_out_valid = (r_out_valid && i_out_stall) || o_cmd.finish;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

[rtl/sucs_dpath.sv]
// Datapath of the unique common substring search: string stores, match-length rows, result.
`timescale 1ns / 1ps

module sucs_dpath
    import sucs_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
)(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    input  logic [7:0] i_symbol,
    output t_status    o_status,
    output t_out_req   o_res
);

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int BW = CW + 1;

    // String stores and match-length rows (row holds lcp against the row below)
    logic [7:0]    mem_first  [MAX_LEN];
    logic [7:0]    mem_second [MAX_LEN];
    logic [CW-1:0] mem_row1   [MAX_LEN];
    logic [CW-1:0] mem_row2   [MAX_LEN];

    logic [CW-1:0] r_first_cnt, r_second_cnt;
    logic          r_dropped;
    logic [AW-1:0] r_i, r_j, r_s2_j;
    logic          r_s2_valid;
    logic [CW-1:0] r_len;
    logic [7:0]    r_ft_i, r_ft_j, r_st_j;
    logic [CW-1:0] r_row1, r_row2;
    logic [CW-1:0] r_a, r_l1, r_l2;
    logic [BW-1:0] r_best;
    logic          r_found;
    t_out_req      r_res;

    logic [AW-1:0] row_addr;
    logic [CW-1:0] i_ext, j_ext;
    logic          last_i, valid1, valid2, last1, last2;
    logic [CW-1:0] new1, new2;
    logic [CW-1:0] top_a;
    logic [BW-1:0] cand;
    logic          hit;
    logic          full_first, full_second;

    assign row_addr = r_j + AW'(1);
    assign i_ext    = CW'(r_i);
    assign j_ext    = CW'(r_s2_j);

    assign full_first  = (r_first_cnt == CW'(MAX_LEN));
    assign full_second = (r_second_cnt == CW'(MAX_LEN));

    // Stores: written while loading, read during the sweep
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_first && !full_first) mem_first[r_first_cnt[AW-1:0]] <= i_symbol;
        r_ft_j <= mem_first[r_j];
        r_ft_i <= mem_first[r_i];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_second && !full_second) mem_second[r_second_cnt[AW-1:0]] <= i_symbol;
        r_st_j <= mem_second[r_j];
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_valid) mem_row1[r_s2_j] <= new1;
        r_row1 <= mem_row1[row_addr];
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_valid) mem_row2[r_s2_j] <= new2;
        r_row2 <= mem_row2[row_addr];
    end

    // Match length recurrence: lcp(i,p) = eq ? 1 + lcp(i+1,p+1) : 0
    assign last_i = (i_ext + CW'(1)) == r_first_cnt;
    assign valid1 = j_ext < r_first_cnt;
    assign valid2 = j_ext < r_second_cnt;
    assign last1  = last_i || ((j_ext + CW'(1)) == r_first_cnt);
    assign last2  = last_i || ((j_ext + CW'(1)) == r_second_cnt);

    always_comb begin
        new1 = '0;
        new2 = '0;
        if (valid1 && (r_ft_i == r_ft_j)) new1 = last1 ? CW'(1) : r_row1 + CW'(1);
        if (valid2 && (r_ft_i == r_st_j)) new2 = last2 ? CW'(1) : r_row2 + CW'(1);
    end

    // Shortest length unique in both: above every other self match and the
    // second best match in the second string, no longer than the best one
    assign top_a = (r_a > r_l2) ? r_a : r_l2;
    assign cand  = BW'(top_a) + BW'(1);
    assign hit   = cand <= BW'(r_l1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_cnt  <= '0;
            r_second_cnt <= '0;
            r_dropped    <= 1'b0;
            r_s2_valid   <= 1'b0;
        end else begin
            r_s2_valid <= i_cmd.issue;
            if (i_cmd.load_first) begin
                if (full_first) r_dropped <= 1'b1;
                else            r_first_cnt <= r_first_cnt + CW'(1);
            end
            if (i_cmd.load_second) begin
                if (full_second) r_dropped <= 1'b1;
                else             r_second_cnt <= r_second_cnt + CW'(1);
            end
            if (i_cmd.finish) begin
                r_first_cnt  <= '0;
                r_second_cnt <= '0;
                r_dropped    <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_j <= r_j;
        if (i_cmd.start) begin
            r_i     <= AW'(r_first_cnt - CW'(1));
            r_j     <= '0;
            r_len   <= (r_first_cnt > r_second_cnt) ? r_first_cnt : r_second_cnt;
            r_found <= 1'b0;
            r_best  <= '0;
        end
        if (i_cmd.issue) r_j <= r_j + AW'(1);

        if (r_s2_valid) begin
            if (valid1 && (r_s2_j != r_i) && (new1 > r_a)) r_a <= new1;
            if (new2 > r_l1) begin
                r_l1 <= new2;
                r_l2 <= r_l1;
            end else if (new2 > r_l2) begin
                r_l2 <= new2;
            end
        end

        if (i_cmd.eval) begin
            if (hit && (!r_found || (cand < r_best))) begin
                r_best  <= cand;
                r_found <= 1'b1;
            end
            r_i <= r_i - AW'(1);
            r_j <= '0;
        end

        if (i_cmd.start || i_cmd.eval) begin
            r_a  <= '0;
            r_l1 <= '0;
            r_l2 <= '0;
        end

        if (i_cmd.finish) begin
            r_res.found    <= r_found;
            r_res.length   <= r_found ? LENGTH_W'(r_best) : '0;
            r_res.overflow <= r_dropped;
        end
    end

    assign o_status.empty      = (r_first_cnt == '0) || (r_second_cnt == '0);
    assign o_status.sweep_last = (CW'(r_j) + CW'(1)) == r_len;
    assign o_status.row_last   = (r_i == '0);
    assign o_res = r_res;

endmodule

[rtl/shortest_unique_common_substring_top.sv]
// Top level of the shortest unique common substring search engine.
`timescale 1ns / 1ps
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_req) takes one request per
//   accepted edge. Mode 0 appends the symbol to the first string, mode 1 to
//   the second; a byte beyond capacity is dropped and sets the overflow flag.
//   Mode 2 runs the search, mode 3 is taken and ignored.
//   Loads may continue while a result waits.
//   A search with n bytes in the first string and m in the second runs one
//   row sweep of max(n,m) entries per start position of the first string,
//   one match-length entry per cycle from each row memory, plus one drain
//   and one evaluate step per row. If either string is empty the search
//   goes straight to the done state without a sweep.
//   Output channel (o_out_valid / i_out_stall / o_out_req) carries found,
//   length and overflow. The result register holds while the receiver
//   stalls; a new search request is stalled until it has been taken.
//   After a search both strings and the overflow flag are empty again.
//   Reset (i_rst_n low, synchronous) empties both strings, clears overflow
//   and drops any pending result. String bytes are not cleared.

module shortest_unique_common_substring_top
    import sucs_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
)(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_req  i_in_req,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_out_req o_out_req
);

    t_cmd    cmd;
    t_status status;

    // Sequencer: handshakes, search row loop
    sucs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_mode      (i_in_req.mode),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    // Stores, match-length recurrence, per-row evaluation and result register
    sucs_dpath #(
        .MAX_LEN (MAX_LEN)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_symbol (i_in_req.symbol),
        .o_status (status),
        .o_res    (o_out_req)
    );

endmodule

[dv/tb_shortest_unique_common_substring_top.sv]
// Self-checking testbench for the shortest unique common substring search engine.
`timescale 1ns / 1ps

module tb_shortest_unique_common_substring_top;
    import sucs_pkg::*;

    localparam int MAX_LEN      = MAX_LEN_DEF;
    // Watchdog limit for the whole run.
    localparam int CYCLE_LIMIT  = 1_000_000;
    // Quiet cycles after the last result.
    localparam int DRAIN_CYCLES = 64;
    // Length of the long receiver hold-off.
    localparam int HOLD_CYCLES  = 600;
    // Counted (non-ignored) requests in the random part.
    localparam int RANDOM_ITEMS = 1150;
    // The package leaves mode 3 unnamed; the block takes and ignores it.
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // ------------------------------------------------------------------
    // Clock, reset and block inputs, all known from time zero
    // ------------------------------------------------------------------
    logic     i_clk     = 1'b0;
    logic     i_rst_n   = 1'b0;
    logic     in_valid  = 1'b0;
    t_in_req  in_req    = '0;
    logic     out_stall = 1'b0;
    logic     o_in_stall;
    logic     o_out_valid;
    t_out_req o_out_req;

    always #5 i_clk = ~i_clk;

    shortest_unique_common_substring_top #(
        .MAX_LEN(MAX_LEN)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (o_in_stall),
        .i_in_req   (in_req),
        .o_out_valid(o_out_valid),
        .i_out_stall(out_stall),
        .o_out_req  (o_out_req)
    );

    // ------------------------------------------------------------------
    // Predictor state: the two strings as the block should hold them
    // ------------------------------------------------------------------
    logic [7:0] first_bytes [MAX_LEN];
    logic [7:0] second_bytes[MAX_LEN];
    int         first_len  = 0;
    int         second_len = 0;
    logic       dropped    = 1'b0;

    t_in_req    pending_requests[$];
    t_out_req   expected_results[$];
    t_out_req   oldest_result;

    int n_counted      = 0;
    int n_ignored      = 0;
    int total_requests = 1;
    int n_accepted     = 0;
    int n_checked      = 0;
    int n_found        = 0;
    int n_overflow     = 0;
    int n_errors       = 0;
    int cycles         = 0;
    int hold_left      = 0;
    bit hold_done      = 1'b0;

    // Occurrences (overlapping, capped at 2) of first_bytes[start +: plen]
    // in the first or the second string.
    function automatic int hits_in(input bit in_second, input int start, input int plen);
        int         tlen;
        int         hits;
        int         p;
        int         k;
        bit         same;
        logic [7:0] b;
        tlen = in_second ? second_len : first_len;
        hits = 0;
        if (plen == 0 || plen > tlen) return 0;
        for (p = 0; p + plen <= tlen; p++) begin
            same = 1'b1;
            for (k = 0; k < plen && same; k++) begin
                b = in_second ? second_bytes[p + k] : first_bytes[p + k];
                if (b != first_bytes[start + k]) same = 1'b0;
            end
            if (same) begin
                hits++;
                if (hits >= 2) return hits;
            end
        end
        return hits;
    endfunction

    // Shortest length with a substring of the first string that is unique
    // in both strings; lengths ascend, start positions ascend, first hit wins.
    function automatic int unique_common_len();
        int lim;
        int c;
        int i;
        lim = (first_len < second_len) ? first_len : second_len;
        for (c = 1; c <= lim; c++) begin
            for (i = 0; i + c <= first_len; i++) begin
                if (hits_in(1'b0, i, c) == 1 && hits_in(1'b1, i, c) == 1) return c;
            end
        end
        return 0;
    endfunction

    // Advance the predictor by one accepted request.
    task automatic apply_request(input t_in_req r);
        int       len;
        t_out_req res;
        case (r.mode)
            MODE_LOAD_FIRST: begin
                if (first_len < MAX_LEN) begin
                    first_bytes[first_len] = r.symbol;
                    first_len++;
                end else begin
                    dropped = 1'b1;
                end
            end
            MODE_LOAD_SECOND: begin
                if (second_len < MAX_LEN) begin
                    second_bytes[second_len] = r.symbol;
                    second_len++;
                end else begin
                    dropped = 1'b1;
                end
            end
            MODE_SEARCH: begin
                len          = unique_common_len();
                res.found    = (len != 0);
                res.length   = len[LENGTH_W-1:0];
                res.overflow = dropped;
                expected_results = {expected_results, res};
                // strings and overflow start over after every search
                first_len  = 0;
                second_len = 0;
                dropped    = 1'b0;
            end
            default: begin
            end
        endcase
    endtask

    // Idling schedule, by progress through the stimulus: sender 33 / receiver
    // 48, then swapped, then a final third with no idling on either side.
    function automatic int idle_pct(input bit receiver);
        int ph;
        ph = (n_accepted * 3) / total_requests;
        if (ph >= 2) return 0;
        if (ph == 0) return receiver ? 48 : 33;
        return receiver ? 33 : 48;
    endfunction

    task automatic push_req(input logic [1:0] mode, input logic [7:0] symbol);
        t_in_req r;
        r.mode   = mode;
        r.symbol = symbol;
        pending_requests = {pending_requests, r};
        if (mode == MODE_UNUSED) n_ignored++;
        else n_counted++;
    endtask

    // ------------------------------------------------------------------
    // Driver: offers queued requests, holds a stalled request unchanged
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall) begin
                apply_request(in_req);
                n_accepted++;
            end
            // slot is free when nothing is offered or the offer was just taken
            if (!in_valid || !o_in_stall) begin
                if (pending_requests.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b0)) begin
                    in_req   <= pending_requests.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Long receiver hold-off, counted here: starts after the third result,
    // the result register stays full, loads keep flowing and the next
    // search request backs up the input.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && n_checked >= 3) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each taken result, drives the output stall
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result: found=%0d length=%0d overflow=%0d",
                           o_out_req.found, o_out_req.length, o_out_req.overflow);
                    n_errors++;
                end else begin
                    oldest_result = expected_results.pop_front();
                    if (o_out_req.found !== oldest_result.found) begin
                        $error("found: expected %0d, actual %0d",
                               oldest_result.found, o_out_req.found);
                        n_errors++;
                    end
                    if (o_out_req.length !== oldest_result.length) begin
                        $error("length: expected %0d, actual %0d",
                               oldest_result.length, o_out_req.length);
                        n_errors++;
                    end
                    if (o_out_req.overflow !== oldest_result.overflow) begin
                        $error("overflow: expected %0d, actual %0d",
                               oldest_result.overflow, o_out_req.overflow);
                        n_errors++;
                    end
                    if (oldest_result.found) n_found++;
                    if (oldest_result.overflow) n_overflow++;
                end
                n_checked++;
            end
            if (hold_left > 0) begin
                out_stall <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(0, 99) < idle_pct(1'b1));
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb_shortest_unique_common_substring_top: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus, reset and end of run
    // ------------------------------------------------------------------
    initial begin : stimulus
        int         n1;
        int         n2;
        int         k;
        int         ia;
        int         ib;
        int         asz;
        int         sel;
        int         offset;
        int         rand_start;
        bit         did_full;
        bit         did_second_full;
        logic [7:0] base;
        logic [7:0] sym;
        logic [7:0] seq_first[64];

        did_full        = 1'b0;
        did_second_full = 1'b0;

        // --- directed ---
        // both strings empty; symbol ignored on a search
        push_req(MODE_SEARCH, 8'hFF);
        // unused mode: no effect, no result
        push_req(MODE_UNUSED, 8'h5A);
        // single equal bytes: hit at length 1
        push_req(MODE_LOAD_FIRST, 8'h00);
        push_req(MODE_LOAD_SECOND, 8'h00);
        push_req(MODE_SEARCH, 8'h00);
        // different bytes: no hit
        push_req(MODE_LOAD_FIRST, 8'hFF);
        push_req(MODE_LOAD_SECOND, 8'h00);
        push_req(MODE_SEARCH, 8'h00);
        // first string empty, second not
        push_req(MODE_LOAD_SECOND, 8'h11);
        push_req(MODE_SEARCH, 8'hAA);
        // repeated byte in the first string, shorter second string: no hit
        push_req(MODE_LOAD_FIRST, 8'hFF);
        push_req(MODE_UNUSED, 8'hFF);
        push_req(MODE_LOAD_FIRST, 8'hFF);
        push_req(MODE_LOAD_SECOND, 8'hFF);
        push_req(MODE_SEARCH, 8'h55);
        // reversed pair, first start position gives the hit
        push_req(MODE_LOAD_FIRST, 8'h80);
        push_req(MODE_LOAD_FIRST, 8'h01);
        push_req(MODE_LOAD_SECOND, 8'h01);
        push_req(MODE_LOAD_SECOND, 8'h80);
        push_req(MODE_SEARCH, 8'h00);
        // second string empty, first not
        push_req(MODE_LOAD_FIRST, 8'h7F);
        push_req(MODE_SEARCH, 8'h00);

        // --- random ---
        rand_start = n_counted;
        while (n_counted < rand_start + RANDOM_ITEMS) begin
            if (!did_full && n_counted > rand_start + 200) begin
                // Both strings full of one byte, one extra byte dropped from the
                // first: the only unique substring is the whole string.
                did_full = 1'b1;
                for (k = 0; k < MAX_LEN + 1; k++) push_req(MODE_LOAD_FIRST, 8'hAA);
                for (k = 0; k < MAX_LEN; k++) push_req(MODE_LOAD_SECOND, 8'hAA);
                push_req(MODE_SEARCH, 8'($urandom_range(0, 255)));
            end else if (!did_second_full && n_counted > rand_start + 600) begin
                // second string overflows, first stays short so the scan is quick
                did_second_full = 1'b1;
                push_req(MODE_LOAD_FIRST, 8'($urandom_range(0, 255)));
                push_req(MODE_LOAD_FIRST, 8'($urandom_range(0, 255)));
                for (k = 0; k < MAX_LEN + 2; k++)
                    push_req(MODE_LOAD_SECOND, 8'($urandom_range(0, 255)));
                push_req(MODE_SEARCH, 8'($urandom_range(0, 255)));
            end else begin
                // short strings, mostly over a narrow alphabet, so repeats and hits occur
                sel  = $urandom_range(0, 3);
                asz  = (sel == 0) ? 2 : (sel == 1) ? 4 : (sel == 2) ? 16 : 256;
                base = 8'($urandom_range(0, 255));
                n1   = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
                n2   = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
                for (k = 0; k < n1; k++) seq_first[k] = base + 8'($urandom_range(0, asz - 1));
                offset = (n1 > 0) ? $urandom_range(0, n1 - 1) : 0;
                ia = 0;
                ib = 0;
                while (ia < n1 || ib < n2) begin
                    if ($urandom_range(0, 19) == 0)
                        push_req(MODE_UNUSED, 8'($urandom_range(0, 255)));
                    if (ib >= n2 || (ia < n1 && $urandom_range(0, 1) == 1)) begin
                        push_req(MODE_LOAD_FIRST, seq_first[ia]);
                        ia++;
                    end else begin
                        // second string mostly follows a run of the first
                        if (n1 > 0 && $urandom_range(0, 3) != 0) begin
                            sym = seq_first[(offset + ib) % n1];
                        end else begin
                            sym = base + 8'($urandom_range(0, asz - 1));
                        end
                        push_req(MODE_LOAD_SECOND, sym);
                        ib++;
                    end
                end
                // now and then no search: the next sequence appends to these strings
                if ($urandom_range(0, 11) != 0)
                    push_req(MODE_SEARCH, 8'($urandom_range(0, 255)));
            end
        end
        push_req(MODE_SEARCH, 8'($urandom_range(0, 255)));
        total_requests = pending_requests.size();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            $error("%0d expected results never arrived", expected_results.size());
            n_errors++;
        end

        $display("run: %0d load/search requests plus %0d unused-mode requests, %0d searches",
                 n_counted, n_ignored, n_checked);
        $display("run: %0d searches found a substring, %0d reported overflow",
                 n_found, n_overflow);
        if (n_errors == 0) begin
            $display("tb_shortest_unique_common_substring_top: done, clean");
        end else begin
            $display("tb_shortest_unique_common_substring_top: done, errors");
        end
        $finish;
    end

endmodule
